// ----- design/chgw_pkg.sv -----
// Shared types and constants for the gift-wrap convex hull block.
package chgw_pkg;

	// Width of the emitted vertex index; wider indexes are truncated to it.
	localparam int INDEX_W = 5;

	typedef enum logic [7:0] {
		S_LOAD = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_EVAL = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_ACC  = 8'b0001_0000,
		S_STEP = 8'b0010_0000,
		S_HOP  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	// Micro-ops of the shared multiply-accumulate unit, in issue order.
	typedef enum logic [2:0] {
		OP_BX_IY = 3'd0,
		OP_BY_IX = 3'd1,
		OP_IX_IX = 3'd2,
		OP_IY_IY = 3'd3,
		OP_BX_BX = 3'd4,
		OP_BY_BY = 3'd5
	} mac_op_t;

endpackage

// ----- design/chgw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module chgw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/convex_hull_gift_wrap.sv -----
// Gift-wrap convex hull: loads points and walks the hull of the set when a point is flagged last.
// point_stall is low only between walks. Each hull vertex costs a scan of all n stored points
// through one shared multiplier and accumulator: each point is read and evaluated, a real
// candidate adds the cross product and a collinear tie the distance check; then the block
// steps, loads the output register and transfers, plus any stall.
// Reset clears all control state; the point RAM keeps its contents, read only below the count.
module convex_hull_gift_wrap #(
	parameter int MAX_POINTS = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic                                last_point,
	output logic                                hull_valid,
	input  logic                                hull_stall,
	output logic [chgw_pkg::INDEX_W-1:0]        hull_index,
	output logic signed [COORD_BITS-1:0]        hull_x,
	output logic signed [COORD_BITS-1:0]        hull_y,
	output logic                                last_of_hull
);

	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int K_W    = $clog2(MAX_POINTS + 2);
	localparam int D      = COORD_BITS + 1;
	localparam int ACC_W  = 2 * D + 2;

	chgw_pkg::state_t  state_q;
	chgw_pkg::mac_op_t op_q;

	logic [CNT_W-1:0]             count_q;
	logic [ADDR_W-1:0]            scan_q;
	logic [ADDR_W-1:0]            start_idx_q;
	logic [ADDR_W-1:0]            best_idx_q;
	logic [K_W-1:0]               k_q;
	logic                         found_q;
	logic signed [COORD_BITS-1:0] sx_q, sy_q, cx_q, cy_q, bx_q, by_q, candx_q, candy_q;
	logic signed [D-1:0]          dbx_q, dby_q, ix_q, iy_q;
	logic signed [2*D-1:0]        prod_q;
	logic signed [ACC_W-1:0]      acc_q;

	logic [ADDR_W-1:0]            hull_index_q;
	logic signed [COORD_BITS-1:0] hull_x_q, hull_y_q;
	logic                         hull_last_q;
	logic                         hull_valid_q;

	// Point store
	logic                         in_xfer;
	logic                         store_en;
	logic [2*COORD_BITS-1:0]      rdata;
	logic signed [COORD_BITS-1:0] px, py;

	assign point_stall = (state_q != chgw_pkg::S_LOAD);
	assign in_xfer     = point_valid && !point_stall;
	assign store_en    = in_xfer && (count_q < CNT_W'(MAX_POINTS));

	chgw_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({point_y, point_x}),
		.re    (state_q == chgw_pkg::S_RD),
		.raddr (scan_q),
		.rdata (rdata)
	);

	assign px = rdata[COORD_BITS-1:0];
	assign py = rdata[2*COORD_BITS-1:COORD_BITS];

	// Lowest point, then leftmost, then lowest index, tracked as points arrive
	logic                         take_start;
	logic signed [COORD_BITS-1:0] sx_next, sy_next;
	logic [ADDR_W-1:0]            start_idx_next;

	always_comb begin
		take_start = store_en && ((count_q == '0) || (point_y < sy_q) ||
			((point_y == sy_q) && (point_x < sx_q)));
		sx_next        = take_start ? point_x : sx_q;
		sy_next        = take_start ? point_y : sy_q;
		start_idx_next = take_start ? count_q[ADDR_W-1:0] : start_idx_q;
	end

	// Scan evaluation
	logic                same_cur;
	logic signed [D-1:0] ix, iy;
	logic                scan_last;

	assign same_cur  = (px == cx_q) && (py == cy_q);
	assign ix        = {px[COORD_BITS-1], px} - {cx_q[COORD_BITS-1], cx_q};
	assign iy        = {py[COORD_BITS-1], py} - {cy_q[COORD_BITS-1], cy_q};
	assign scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);

	// Shared multiply-accumulate unit
	logic signed [D-1:0]     mul_a, mul_b;
	logic signed [2*D-1:0]   mul_p;
	logic signed [ACC_W-1:0] acc_base, prod_ext, acc_new;
	logic                    acc_neg, acc_zero;

	always_comb begin
		case (op_q)
			chgw_pkg::OP_BX_IY: begin mul_a = dbx_q; mul_b = iy_q;  end
			chgw_pkg::OP_BY_IX: begin mul_a = dby_q; mul_b = ix_q;  end
			chgw_pkg::OP_IX_IX: begin mul_a = ix_q;  mul_b = ix_q;  end
			chgw_pkg::OP_IY_IY: begin mul_a = iy_q;  mul_b = iy_q;  end
			chgw_pkg::OP_BX_BX: begin mul_a = dbx_q; mul_b = dbx_q; end
			chgw_pkg::OP_BY_BY: begin mul_a = dby_q; mul_b = dby_q; end
			default:            begin mul_a = '0;    mul_b = '0;    end
		endcase
		mul_p    = mul_a * mul_b;
		prod_ext = ACC_W'(prod_q);
		acc_base = ((op_q == chgw_pkg::OP_BX_IY) || (op_q == chgw_pkg::OP_IX_IX)) ?
			'0 : acc_q;
		case (op_q)
			chgw_pkg::OP_BY_IX,
			chgw_pkg::OP_BX_BX,
			chgw_pkg::OP_BY_BY: acc_new = acc_base - prod_ext;
			default:            acc_new = acc_base + prod_ext;
		endcase
		acc_neg  = acc_new[ACC_W-1];
		acc_zero = (acc_new == '0);
	end

	logic hull_closing;
	assign hull_closing = ((bx_q == sx_q) && (by_q == sy_q)) || (k_q >= K_W'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= chgw_pkg::S_LOAD;
			op_q         <= chgw_pkg::OP_BX_IY;
			count_q      <= '0;
			scan_q       <= '0;
			start_idx_q  <= '0;
			best_idx_q   <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			hull_valid_q <= 1'b0;
		end else begin
			case (state_q)
				chgw_pkg::S_LOAD: begin
					if (in_xfer) begin
						sx_q        <= sx_next;
						sy_q        <= sy_next;
						start_idx_q <= start_idx_next;
						if (store_en) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_point) begin
							cx_q    <= sx_next;
							cy_q    <= sy_next;
							scan_q  <= '0;
							found_q <= 1'b0;
							k_q     <= '0;
							state_q <= chgw_pkg::S_RD;
						end
					end
				end
				chgw_pkg::S_RD: begin
					state_q <= chgw_pkg::S_EVAL;
				end
				chgw_pkg::S_EVAL: begin
					candx_q <= px;
					candy_q <= py;
					ix_q    <= ix;
					iy_q    <= iy;
					if (!same_cur && found_q) begin
						op_q    <= chgw_pkg::OP_BX_IY;
						state_q <= chgw_pkg::S_MUL;
					end else begin
						if (!same_cur) begin
							// first distinct point seeds the candidate
							found_q    <= 1'b1;
							best_idx_q <= scan_q;
							bx_q       <= px;
							by_q       <= py;
							dbx_q      <= ix;
							dby_q      <= iy;
						end
						if (scan_last) begin
							state_q <= chgw_pkg::S_STEP;
						end else begin
							scan_q  <= scan_q + ADDR_W'(1);
							state_q <= chgw_pkg::S_RD;
						end
					end
				end
				chgw_pkg::S_MUL: begin
					prod_q  <= mul_p;
					state_q <= chgw_pkg::S_ACC;
				end
				chgw_pkg::S_ACC: begin
					logic replace;
					logic more;
					replace = 1'b0;
					more    = 1'b0;
					acc_q   <= acc_new;
					case (op_q)
						chgw_pkg::OP_BY_IX: begin
							// clockwise wins; collinear goes to the distance check
							replace = acc_neg;
							more    = acc_zero;
						end
						chgw_pkg::OP_BY_BY: begin
							replace = !acc_neg && !acc_zero;
						end
						default: begin
							more = 1'b1;
						end
					endcase
					if (replace) begin
						best_idx_q <= scan_q;
						bx_q       <= candx_q;
						by_q       <= candy_q;
						dbx_q      <= ix_q;
						dby_q      <= iy_q;
					end
					if (more) begin
						op_q    <= chgw_pkg::mac_op_t'(op_q + 3'd1);
						state_q <= chgw_pkg::S_MUL;
					end else if (scan_last) begin
						state_q <= chgw_pkg::S_STEP;
					end else begin
						scan_q  <= scan_q + ADDR_W'(1);
						state_q <= chgw_pkg::S_RD;
					end
				end
				chgw_pkg::S_STEP: begin
					if (k_q == '0) begin
						hull_index_q <= start_idx_q;
						hull_x_q     <= sx_q;
						hull_y_q     <= sy_q;
						hull_last_q  <= !found_q;
						hull_valid_q <= 1'b1;
						k_q          <= K_W'(1);
						state_q      <= chgw_pkg::S_OUT;
					end else if (found_q) begin
						state_q <= chgw_pkg::S_HOP;
					end else begin
						count_q <= '0;
						state_q <= chgw_pkg::S_LOAD;
					end
				end
				chgw_pkg::S_HOP: begin
					cx_q         <= bx_q;
					cy_q         <= by_q;
					hull_index_q <= best_idx_q;
					hull_x_q     <= bx_q;
					hull_y_q     <= by_q;
					hull_last_q  <= hull_closing;
					hull_valid_q <= 1'b1;
					k_q          <= k_q + K_W'(1);
					state_q      <= chgw_pkg::S_OUT;
				end
				chgw_pkg::S_OUT: begin
					if (hull_valid_q && !hull_stall) begin
						hull_valid_q <= 1'b0;
						if (hull_last_q) begin
							count_q <= '0;
							state_q <= chgw_pkg::S_LOAD;
						end else if (k_q == K_W'(1)) begin
							// start vertex out; step to the vertex found by the first scan
							state_q <= chgw_pkg::S_HOP;
						end else begin
							scan_q  <= '0;
							found_q <= 1'b0;
							state_q <= chgw_pkg::S_RD;
						end
					end
				end
				default: begin
					state_q <= chgw_pkg::S_LOAD;
				end
			endcase
		end
	end

	assign hull_valid   = hull_valid_q;
	assign hull_index   = chgw_pkg::INDEX_W'(hull_index_q);
	assign hull_x       = hull_x_q;
	assign hull_y       = hull_y_q;
	assign last_of_hull = hull_last_q;

endmodule

// ----- tb/convex_hull_gift_wrap_test.sv -----
// Testbench for the gift-wrap convex hull block: directed and random point sets, scored vertices.
module convex_hull_gift_wrap_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PTS = 32;
	localparam int CRD_W   = 16;
	localparam int MAX_VTX = MAX_PTS + 1;

	typedef logic signed [CRD_W-1:0] coord_t;

	typedef struct {
		logic [chgw_pkg::INDEX_W-1:0] index;
		coord_t                       x;
		coord_t                       y;
		logic                         last;
	} hull_vertex_t;

	// How the coordinates of one random set are drawn
	typedef enum int {
		MIX_FULL,
		MIX_GRID,
		MIX_EXTREME,
		MIX_LINE
	} point_mix_t;

	logic                         clk;
	logic                         arst_n      = 1'b0;
	logic                         point_valid = 1'b0;
	logic                         point_stall;
	coord_t                       point_x     = '0;
	coord_t                       point_y     = '0;
	logic                         last_point  = 1'b0;
	logic                         hull_valid;
	logic                         hull_stall  = 1'b0;
	logic [chgw_pkg::INDEX_W-1:0] hull_index;
	coord_t                       hull_x;
	coord_t                       hull_y;
	logic                         last_of_hull;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors        = 0;

	// Shadow copy of the point store and the vertices still owed by the block
	coord_t       set_x [MAX_PTS];
	coord_t       set_y [MAX_PTS];
	int           set_count = 0;
	hull_vertex_t hull_expect_q [$];

	convex_hull_gift_wrap #(
		.MAX_POINTS(MAX_PTS),
		.COORD_BITS(CRD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point),
		.hull_valid(hull_valid),
		.hull_stall(hull_stall),
		.hull_index(hull_index),
		.hull_x(hull_x),
		.hull_y(hull_y),
		.last_of_hull(last_of_hull)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("convex_hull_gift_wrap_test NOT OK");
		$finish;
	end

	function automatic bit same_coords(int a, int b);
		return set_x[a] == set_x[b] && set_y[a] == set_y[b];
	endfunction

	// Pick the point with nothing clockwise of it as seen from cur; -1 if none differs.
	function automatic int wrap_next(int cur);
		int     best;
		longint bx, by, ix, iy, cr;
		best = -1;
		for (int i = 0; i < set_count; i++) begin
			if (same_coords(i, cur))
				continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			bx = longint'(set_x[best]) - longint'(set_x[cur]);
			by = longint'(set_y[best]) - longint'(set_y[cur]);
			ix = longint'(set_x[i]) - longint'(set_x[cur]);
			iy = longint'(set_y[i]) - longint'(set_y[cur]);
			cr = bx * iy - by * ix;
			if (cr < 0)
				best = i;
			else if (cr == 0 && ix * ix + iy * iy > bx * bx + by * by)
				best = i;
		end
		return best;
	endfunction

	function automatic void owe_vertex(int idx, bit last);
		hull_vertex_t v;
		v.index = idx[chgw_pkg::INDEX_W-1:0];
		v.x     = set_x[idx];
		v.y     = set_y[idx];
		v.last  = last;
		hull_expect_q = {hull_expect_q, v};
	endfunction

	function automatic void wrap_hull();
		int start, cur, nxt, emitted;
		bit closing;
		start = 0;
		for (int i = 1; i < set_count; i++) begin
			if (set_y[i] < set_y[start] || (set_y[i] == set_y[start] && set_x[i] < set_x[start]))
				start = i;
		end
		nxt = wrap_next(start);
		if (nxt < 0) begin
			owe_vertex(start, 1'b1);
		end else begin
			owe_vertex(start, 1'b0);
			emitted = 1;
			cur = nxt;
			forever begin
				closing = same_coords(cur, start) || (emitted + 1 >= MAX_VTX);
				owe_vertex(cur, closing);
				emitted++;
				if (closing)
					break;
				nxt = wrap_next(cur);
				if (nxt < 0) begin
					hull_expect_q[$].last = 1'b1;
					break;
				end
				cur = nxt;
			end
		end
		set_count = 0;
	endfunction

	function automatic void take_point(coord_t x, coord_t y, bit last);
		// drop the point when the store is full
		if (set_count < MAX_PTS) begin
			set_x[set_count] = x;
			set_y[set_count] = y;
			set_count++;
		end
		if (last)
			wrap_hull();
	endfunction

	task automatic send_point(input coord_t x, input coord_t y, input bit last);
		if ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		point_valid <= 1'b1;
		point_x     <= x;
		point_y     <= y;
		last_point  <= last;
		do @(posedge clk); while (point_stall);
		take_point(x, y, last);
	endtask

	// Hold off the sender until every owed vertex has come out
	task automatic wait_for_hulls();
		point_valid <= 1'b0;
		do @(posedge clk); while (hull_expect_q.size() != 0);
	endtask

	always @(posedge clk) begin
		hull_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		hull_vertex_t want;
		if (arst_n && hull_valid && !hull_stall) begin
			if (hull_expect_q.size() == 0) begin
				$error("unexpected hull vertex: index %0d x %0d y %0d", hull_index, hull_x, hull_y);
				errors++;
			end else begin
				want = hull_expect_q.pop_front();
				if (hull_index !== want.index) begin
					$error("hull_index: expected %0d, actual %0d", want.index, hull_index);
					errors++;
				end
				if (hull_x !== want.x) begin
					$error("hull_x: expected %0d, actual %0d", want.x, hull_x);
					errors++;
				end
				if (hull_y !== want.y) begin
					$error("hull_y: expected %0d, actual %0d", want.y, hull_y);
					errors++;
				end
				if (last_of_hull !== want.last) begin
					$error("last_of_hull: expected %0d, actual %0d", want.last, last_of_hull);
					errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point( 16'sd32767, -16'sd32768, 1'b0);
		send_point( 16'sd32767,  16'sd32767, 1'b0);
		send_point(-16'sd32768,  16'sd32767, 1'b1);
	endtask

	task automatic test_single_point();
		send_point(-16'sd1, 16'sd0, 1'b1);
		// all copies of one point: start only
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd5, 16'sd5, 1'b1);
	endtask

	task automatic test_duplicates();
		// copies of hull vertices: lower index wins, current vertex skipped
		send_point(16'sd0,  16'sd0,  1'b0);
		send_point(16'sd10, 16'sd0,  1'b0);
		send_point(16'sd10, 16'sd0,  1'b0);
		send_point(16'sd0,  16'sd10, 1'b0);
		send_point(16'sd0,  16'sd0,  1'b1);
	endtask

	task automatic test_collinear();
		// points on hull edges: the farther one is taken
		send_point(16'sd5,  16'sd0,  1'b0);
		send_point(16'sd0,  16'sd0,  1'b0);
		send_point(16'sd10, 16'sd0,  1'b0);
		send_point(16'sd5,  16'sd5,  1'b0);
		send_point(16'sd10, 16'sd10, 1'b1);
		// two distinct points only
		send_point(16'sd3, 16'sd3, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b1);
	endtask

	function automatic coord_t extreme_coord();
		case ($urandom_range(4))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return -16'sd32767;
			3:       return 16'sd32766;
			default: return 16'sd0;
		endcase
	endfunction

	task automatic test_random_sets(input int n_items);
		int         sent, set_size, r, ox, oy, dx, dy, t;
		point_mix_t mix;
		coord_t     x, y, px, py;
		sent = 0;
		px = '0;
		py = '0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 70)
				set_size = $urandom_range(10, 3);
			else if (r < 82)
				set_size = $urandom_range(31, 11);
			else if (r < 90)
				set_size = $urandom_range(35, 32);
			else
				set_size = $urandom_range(2, 1);
			r = $urandom_range(9);
			mix = r < 4 ? MIX_FULL : r < 7 ? MIX_GRID : r < 8 ? MIX_EXTREME : MIX_LINE;
			ox = int'($urandom_range(2000)) - 1000;
			oy = int'($urandom_range(2000)) - 1000;
			dx = int'($urandom_range(100)) - 50;
			dy = int'($urandom_range(100)) - 50;
			for (int i = 0; i < set_size; i++) begin
				if (i > 0 && $urandom_range(9) == 0) begin
					x = px;
					y = py;
				end else begin
					case (mix)
						MIX_FULL: begin
							x = coord_t'($urandom());
							y = coord_t'($urandom());
						end
						MIX_GRID: begin
							x = coord_t'(int'($urandom_range(16)) - 8);
							y = coord_t'(int'($urandom_range(16)) - 8);
						end
						MIX_EXTREME: begin
							x = extreme_coord();
							y = extreme_coord();
						end
						default: begin
							// mostly on one line, now and then off it
							t = int'($urandom_range(40)) - 20;
							x = coord_t'(ox + t * dx);
							y = coord_t'(oy + t * dy + ($urandom_range(7) == 0 ? 1 : 0));
						end
					endcase
				end
				send_point(x, y, i == set_size - 1);
				px = x;
				py = y;
			end
			sent += set_size;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 49;
		test_extremes();
		test_single_point();
		test_duplicates();
		test_collinear();
		test_random_sets(160);
		wait_for_hulls();

		send_idle_pct = 49;
		recv_idle_pct = 37;
		test_random_sets(160);
		wait_for_hulls();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(160);
		wait_for_hulls();

		repeat (200) @(posedge clk);
		if (errors == 0 && hull_expect_q.size() == 0)
			$display("convex_hull_gift_wrap_test OK");
		else
			$display("convex_hull_gift_wrap_test NOT OK");
		$finish;
	end

endmodule
